FILE: src/nll_pkg.sv
// ============================================================================
// nll_pkg
// Shared widths, constants and the sequencer state type for the nonlinear
// ladder low-pass filter.
// ============================================================================
package nll_pkg;

    // Field and datapath widths.
    localparam int SAMPLE_W = 24;
    localparam int COEF_W   = 18;
    localparam int CUT_W    = 17;
    localparam int TAP_W    = 20;
    localparam int MUL_A_W  = 24;
    localparam int MUL_B_W  = 27;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int ACC_W    = 48;
    localparam int DVD_W    = 48;
    localparam int DVS_W    = 27;
    localparam int QUO_W    = 21;
    localparam int CNT_W    = 5;
    localparam int TANH_W   = 22;
    localparam int ARG_W    = 29;
    localparam int DIFF_W   = 23;
    localparam int X2_W     = 24;

    // Fraction bits of the Q4.20 sample format.
    localparam int FRAC_SHIFT = 20;

    // Cutoff upper clamp, 1.0 in Q.16.
    localparam logic [CUT_W-1:0] CUT_MAX = 17'd65536;

    // Output blend taps in Q.20, tap 0 weights the last stage.
    localparam logic [3:0][TAP_W-1:0] BLEND_TAP = {
        20'd46109, 20'd186537, 20'd437560, 20'd378422
    };

    // Constants of the rational tanh approximation.
    localparam logic [DVS_W-1:0]         C27_Q20    = 27'd28311552;
    localparam logic signed [TANH_W-1:0] ONE_Q20    = 22'sd1048576;
    localparam logic signed [ARG_W-1:0]  THREE_Q20  = 29'sd3145728;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BL_MUL,
        ST_BL_ACC,
        ST_BL_RND,
        ST_FB_MUL,
        ST_FB_ACC,
        ST_TH_CHK,
        ST_TH_SQ,
        ST_TH_X2,
        ST_TH_NUM,
        ST_TH_DIV,
        ST_TH_WAIT,
        ST_STG_MUL,
        ST_STG_UPD,
        ST_FIN
    } nll_state_t;

endpackage

FILE: src/nll_mul.sv
// ============================================================================
// nll_mul
// Shared signed multiplier with a registered product; the product of the
// operands presented in one cycle is available in the next.
// ============================================================================
module nll_mul
    import nll_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_A_W-1:0] op_a,
    input  logic signed [MUL_B_W-1:0] op_b,
    output logic signed [PROD_W-1:0]  prod
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    // Full-precision signed product.
    always_comb
    begin
        prod_next = PROD_W'(op_a) * PROD_W'(op_b);
    end

    // Product register.
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

FILE: src/nll_div.sv
// ============================================================================
// nll_div
// Restoring unsigned divider, one quotient bit per cycle. The quotient is
// known to fit QUO_W bits, so the top dividend bits seed the remainder.
// ============================================================================
module nll_div
    import nll_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [QUO_W-1:0] quotient,
    output logic             done
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] low_reg, low_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   shifted;
    logic [DVS_W+1:0] trial;
    logic             fits;

    // One shift-and-subtract step.
    always_comb
    begin
        shifted = {rem_reg, low_reg[QUO_W-1]};
        trial   = {1'b0, shifted} - {2'b00, dvs_reg};
        fits    = !trial[DVS_W+1];
    end

    // Next-value logic for the iteration registers.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QUO_W - 1);
            rem_next  = dividend[DVD_W-1:QUO_W];
            low_next  = dividend[QUO_W-1:0];
            quo_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
            low_next = {low_reg[QUO_W-2:0], 1'b0};
            quo_next = {quo_reg[QUO_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

    // A new division never starts on top of a running one.
    assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_reg)
        else $error("divider started while busy");

    // Completion only follows a running division.
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

    // The iteration count is within the quotient width while busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg <= CNT_W'(QUO_W - 1))
        else $error("divider count out of range");

endmodule

FILE: src/nonlinear_ladder_lowpass_top.sv
// ============================================================================
// nonlinear_ladder_lowpass_top
// Four-pole tanh ladder low-pass with resonance feedback and a 4-tap output
// blend, computed on one shared multiplier and one iterative divider.
// ============================================================================
// A word is taken only in the idle state, so the block does not accept a new word
// before it is through with the last one. Each tanh runs through the square, the
// numerator and the bit-serial divider, or ends at its check when its argument
// is at or beyond +/-3.0. The previous output word may still wait while the next
// word is computed.
// Reset: asynchronous, active low; clears all stage and delay values to zero.
module nonlinear_ladder_lowpass_top
    import nll_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic signed [COEF_W-1:0]   cutoff,
    input  logic signed [COEF_W-1:0]   resonance,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] sample_out
);

    // Sequencer and control registers.
    nll_state_t state_reg, state_next;
    logic [1:0] idx_reg, idx_next;
    logic       fb_phase_reg, fb_phase_next;
    logic       out_valid_reg, out_valid_next;

    // Filter state.
    logic signed [SAMPLE_W-1:0] stg_reg [4];
    logic signed [SAMPLE_W-1:0] stg_next [4];
    logic signed [TANH_W-1:0]   th_reg [4];
    logic signed [TANH_W-1:0]   th_next [4];
    logic signed [SAMPLE_W-1:0] dly1_reg, dly1_next;
    logic signed [SAMPLE_W-1:0] dly2_reg, dly2_next;
    logic signed [SAMPLE_W-1:0] dly3_reg, dly3_next;

    // Working registers.
    logic signed [SAMPLE_W-1:0] x_reg, x_next;
    logic [CUT_W-1:0]           b_reg, b_next;
    logic signed [COEF_W-1:0]   reso_reg, reso_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [SAMPLE_W-1:0] y_reg, y_next;
    logic signed [ARG_W-1:0]    tv_reg, tv_next;
    logic [X2_W-1:0]            x2_reg, x2_next;
    logic [DVS_W-1:0]           den_reg, den_next;
    logic                       neg_reg, neg_next;
    logic signed [TANH_W-1:0]   drive_reg, drive_next;
    logic signed [SAMPLE_W-1:0] out_reg, out_next;

    // Shared units.
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic                      div_start;
    logic [DVD_W-1:0]          div_dvd;
    logic [QUO_W-1:0]          div_quo;
    logic                      div_done;

    // Datapath terms.
    logic                       accept;
    logic                       out_free;
    logic [CUT_W-1:0]           b_clamped;
    logic signed [SAMPLE_W-1:0] blend_op;
    logic signed [ACC_W-1:0]    acc_rnd;
    logic signed [SAMPLE_W-1:0] y_sat;
    logic signed [PROD_W-1:0]   fb_rnd;
    logic signed [ARG_W-1:0]    arg;
    logic signed [PROD_W-1:0]   inc_rnd;
    logic signed [ARG_W-1:0]    stg_sum;
    logic signed [SAMPLE_W-1:0] stg_new;
    logic signed [DIFF_W-1:0]   diff;
    logic [PROD_W-1:0]          sq_rnd;
    logic [PROD_W-1:0]          prod_abs;
    logic                       th_hi;
    logic                       th_lo;
    logic                       th_clamp;
    logic signed [TANH_W-1:0]   quo_s;
    logic signed [TANH_W-1:0]   t_val;
    logic                       commit;
    nll_state_t                 after_th;

    // Saturate a wide signed value to the sample range.
    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [ARG_W-1:0] v
    );
        logic signed [ARG_W-1:0] hi;
        logic signed [ARG_W-1:0] lo;
        hi = ARG_W'({1'b0, {(SAMPLE_W-1){1'b1}}});
        lo = -hi - ARG_W'(1);
        if (v > hi)
        begin
            return hi[SAMPLE_W-1:0];
        end
        else if (v < lo)
        begin
            return lo[SAMPLE_W-1:0];
        end
        return v[SAMPLE_W-1:0];
    endfunction

    nll_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    nll_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (den_reg),
        .quotient (div_quo),
        .done     (div_done)
    );

    // Arithmetic around the shared units.
    always_comb
    begin
        accept   = in_valid && in_ready;
        out_free = !out_valid_reg || out_ready;

        // Cutoff clamped to 0..1.0.
        if (cutoff[COEF_W-1])
        begin
            b_clamped = '0;
        end
        else if (cutoff[CUT_W-1] && (|cutoff[CUT_W-2:0]))
        begin
            b_clamped = CUT_MAX;
        end
        else
        begin
            b_clamped = cutoff[CUT_W-1:0];
        end

        // Blend operand: the last stage, then the delayed copies.
        case (idx_reg)
            2'd0:    blend_op = stg_reg[3];
            2'd1:    blend_op = dly1_reg;
            2'd2:    blend_op = dly2_reg;
            default: blend_op = dly3_reg;
        endcase

        // Blend sum rounded half up from Q.40 to Q.20, then saturated.
        acc_rnd = acc_reg + ACC_W'(1 << (FRAC_SHIFT - 1));
        y_sat   = sat_sample(ARG_W'(acc_rnd >>> FRAC_SHIFT));

        // Feedback 4 * reso * y: Q.36 rounded to Q.20 is a shift of 14.
        fb_rnd = prod + PROD_W'(1 << 13);
        arg    = ARG_W'(x_reg) - $signed(fb_rnd[ARG_W+13:14]);

        // Stage increment rounded from Q.36 and added to the old value.
        inc_rnd = (prod + PROD_W'(1 << 15)) >>> 16;
        stg_sum = ARG_W'(stg_reg[idx_reg]) + $signed(inc_rnd[ARG_W-1:0]);
        stg_new = sat_sample(stg_sum);
        diff    = DIFF_W'(drive_reg) - DIFF_W'(th_reg[idx_reg]);

        // Square rounded half up to Q.20; the product is never negative.
        sq_rnd = prod + PROD_W'(1 << (FRAC_SHIFT - 1));

        // Rounded quotient of |num| / den.
        prod_abs = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
        div_dvd  = prod_abs[DVD_W-1:0] + DVD_W'(den_reg >> 1);

        // Saturation of the tanh argument at +/-3.0.
        th_hi    = tv_reg >= THREE_Q20;
        th_lo    = tv_reg <= -THREE_Q20;
        th_clamp = th_hi || th_lo;
        quo_s    = TANH_W'(div_quo);

        if (state_reg == ST_TH_CHK)
        begin
            t_val = th_hi ? ONE_Q20 : -ONE_Q20;
        end
        else
        begin
            t_val = neg_reg ? -quo_s : quo_s;
        end

        commit   = ((state_reg == ST_TH_CHK) && th_clamp)
                || ((state_reg == ST_TH_WAIT) && div_done);
        after_th = (!fb_phase_reg && (idx_reg == 2'd3)) ? ST_FIN : ST_STG_MUL;
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (in_valid) state_next = ST_BL_MUL;
            ST_BL_MUL:  state_next = ST_BL_ACC;
            ST_BL_ACC:  state_next = (idx_reg == 2'd3) ? ST_BL_RND : ST_BL_MUL;
            ST_BL_RND:  state_next = ST_FB_MUL;
            ST_FB_MUL:  state_next = ST_FB_ACC;
            ST_FB_ACC:  state_next = ST_TH_CHK;
            ST_TH_CHK:  state_next = th_clamp ? after_th : ST_TH_SQ;
            ST_TH_SQ:   state_next = ST_TH_X2;
            ST_TH_X2:   state_next = ST_TH_NUM;
            ST_TH_NUM:  state_next = ST_TH_DIV;
            ST_TH_DIV:  state_next = ST_TH_WAIT;
            ST_TH_WAIT: if (div_done) state_next = after_th;
            ST_STG_MUL: state_next = ST_STG_UPD;
            ST_STG_UPD: state_next = ST_TH_CHK;
            ST_FIN:     if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Control outputs: handshake and operands of the shared units.
    always_comb
    begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_BL_MUL:
            begin
                mul_a = blend_op;
                mul_b = MUL_B_W'(BLEND_TAP[idx_reg]);
            end
            ST_FB_MUL:
            begin
                mul_a = y_reg;
                mul_b = MUL_B_W'(reso_reg);
            end
            ST_TH_SQ:
            begin
                mul_a = tv_reg[MUL_A_W-1:0];
                mul_b = MUL_B_W'($signed(tv_reg[MUL_A_W-1:0]));
            end
            ST_TH_NUM:
            begin
                mul_a = tv_reg[MUL_A_W-1:0];
                mul_b = C27_Q20 + MUL_B_W'(x2_reg);
            end
            ST_TH_DIV:
            begin
                div_start = 1'b1;
            end
            ST_STG_MUL:
            begin
                mul_a = MUL_A_W'(diff);
                mul_b = MUL_B_W'(b_reg);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Datapath register updates.
    always_comb
    begin
        idx_next       = idx_reg;
        fb_phase_next  = fb_phase_reg;
        out_valid_next = out_valid_reg;
        stg_next       = stg_reg;
        th_next        = th_reg;
        dly1_next      = dly1_reg;
        dly2_next      = dly2_reg;
        dly3_next      = dly3_reg;
        x_next         = x_reg;
        b_next         = b_reg;
        reso_next      = reso_reg;
        acc_next       = acc_reg;
        y_next         = y_reg;
        tv_next        = tv_reg;
        x2_next        = x2_reg;
        den_next       = den_reg;
        neg_next       = neg_reg;
        drive_next     = drive_reg;
        out_next       = out_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    x_next    = sample_in;
                    b_next    = b_clamped;
                    reso_next = resonance;
                    acc_next  = '0;
                    idx_next  = '0;
                end
            end
            ST_BL_ACC:
            begin
                acc_next = acc_reg + ACC_W'(prod);
                idx_next = idx_reg + 2'd1;
            end
            ST_BL_RND:
            begin
                y_next    = y_sat;
                dly3_next = dly2_reg;
                dly2_next = dly1_reg;
                dly1_next = stg_reg[3];
                idx_next  = '0;
            end
            ST_FB_ACC:
            begin
                tv_next       = arg;
                fb_phase_next = 1'b1;
            end
            ST_TH_X2:
            begin
                x2_next = sq_rnd[FRAC_SHIFT+X2_W-1:FRAC_SHIFT];
            end
            ST_TH_NUM:
            begin
                den_next = C27_Q20 + {x2_reg, 3'b000} + DVS_W'(x2_reg);
            end
            ST_TH_DIV:
            begin
                neg_next = prod[PROD_W-1];
            end
            ST_STG_UPD:
            begin
                stg_next[idx_reg] = stg_new;
                tv_next           = ARG_W'(stg_new);
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_next       = y_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase

        // A finished tanh drives the next stage and, for a stage value,
        // is kept as that stage's tanh for the following sample.
        if (commit)
        begin
            drive_next = t_val;
            if (fb_phase_reg)
            begin
                fb_phase_next = 1'b0;
            end
            else
            begin
                th_next[idx_reg] = t_val;
                idx_next         = idx_reg + 2'd1;
            end
        end
    end

    // Control and filter state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            fb_phase_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                stg_reg[i] <= '0;
                th_reg[i]  <= '0;
            end
            dly1_reg <= '0;
            dly2_reg <= '0;
            dly3_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            fb_phase_reg  <= fb_phase_next;
            out_valid_reg <= out_valid_next;
            stg_reg       <= stg_next;
            th_reg        <= th_next;
            dly1_reg      <= dly1_next;
            dly2_reg      <= dly2_next;
            dly3_reg      <= dly3_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        b_reg     <= b_next;
        reso_reg  <= reso_next;
        acc_reg   <= acc_next;
        y_reg     <= y_next;
        tv_reg    <= tv_next;
        x2_reg    <= x2_next;
        den_reg   <= den_next;
        neg_reg   <= neg_next;
        drive_reg <= drive_next;
        out_reg   <= out_next;
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_reg;

    // An accepted word always starts the blend.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_BL_MUL)
        else $error("accepted word did not start the blend");

    // The feedback tanh is always followed by the first stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        fb_phase_reg |-> idx_reg == 2'd0)
        else $error("feedback tanh with a stage index other than the first");

    // The working cutoff never exceeds 1.0.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> b_reg <= CUT_MAX)
        else $error("cutoff coefficient above 1.0");

    // The divider only runs while the sequencer waits on it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_TH_WAIT)
        else $error("division finished outside the wait state");

endmodule

FILE: tb/nll_ladder_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// nll_ladder_checker
// Watches both channels of the ladder low-pass, predicts every output word
// from the accepted input words with its own fixed-point ladder model, and
// compares each output word with the oldest prediction still waiting.
// ============================================================================
module nll_ladder_checker
    import nll_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic signed [COEF_W-1:0]   cutoff,
    input  logic signed [COEF_W-1:0]   resonance,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic signed [SAMPLE_W-1:0] sample_out,
    output int                         mismatches,
    output int                         pending_words
);

    // Q.20 unit, Q4.20 limits and the Q.16 cutoff ceiling.
    localparam longint Q20_UNIT  = 1048576;
    localparam longint S24_TOP   = 8388607;
    localparam longint S24_FLOOR = -8388608;
    localparam longint CUT_CEIL  = 65536;

    // Output blend weights in Q.20, newest stage value first.
    localparam longint MIX_W0 = 378422;
    localparam longint MIX_W1 = 437560;
    localparam longint MIX_W2 = 186537;
    localparam longint MIX_W3 = 46109;

    // Mirror of the filter state: four ladder stages and the stage-four history.
    longint ladder_stage [4];
    longint stage4_hist  [3];

    // Predicted output words in acceptance order.
    logic signed [SAMPLE_W-1:0] predicted_words [$];
    logic signed [SAMPLE_W-1:0] oldest_word;

    // Drop n fraction bits, rounding half up.
    function automatic longint round_up_shift(input longint v, input int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint clamp_s24(input longint v);
        if (v > S24_TOP)
            return S24_TOP;
        if (v < S24_FLOOR)
            return S24_FLOOR;
        return v;
    endfunction

    // Rational tanh in Q.20, flat at +/-1.0 from +/-3.0 outward.
    function automatic longint soft_clip(input longint x);
        longint x_sq;
        longint num;
        longint den;
        longint mag;
        longint quo;
        if (x >= 3 * Q20_UNIT)
            return Q20_UNIT;
        if (x <= -3 * Q20_UNIT)
            return -Q20_UNIT;
        x_sq = round_up_shift(x * x, 20);
        num  = x * (27 * Q20_UNIT + x_sq);
        den  = 27 * Q20_UNIT + 9 * x_sq;
        mag  = (num < 0) ? -num : num;
        quo  = (mag + den / 2) / den;
        return (num < 0) ? -quo : quo;
    endfunction

    // One filter step: blend the output, shift the history, then walk the ladder.
    function automatic logic signed [SAMPLE_W-1:0] filter_word(input longint x,
                                                               input longint cut_raw,
                                                               input longint reso);
        longint gain;
        longint mix;
        longint fb;
        longint drive;
        gain = (cut_raw < 0) ? 0 : ((cut_raw > CUT_CEIL) ? CUT_CEIL : cut_raw);
        mix  = ladder_stage[3] * MIX_W0 + stage4_hist[0] * MIX_W1
             + stage4_hist[1] * MIX_W2 + stage4_hist[2] * MIX_W3;
        mix  = clamp_s24(round_up_shift(mix, 20));

        stage4_hist[2] = stage4_hist[1];
        stage4_hist[1] = stage4_hist[0];
        stage4_hist[0] = ladder_stage[3];

        // Resonance feedback: gain of four times the resonance on the output.
        fb    = round_up_shift(reso * mix * 4, 16);
        drive = soft_clip(x - fb);
        for (int i = 0; i < 4; i++)
        begin
            ladder_stage[i] = clamp_s24(ladder_stage[i]
                + round_up_shift((drive - soft_clip(ladder_stage[i])) * gain, 16));
            drive = soft_clip(ladder_stage[i]);
        end
        return mix[SAMPLE_W-1:0];
    endfunction

    // Outputs are checked before the new input word is predicted, so a word
    // accepted at this edge can never be matched against an output at the same edge.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                ladder_stage[i] = 0;
            for (int i = 0; i < 3; i++)
                stage4_hist[i] = 0;
            predicted_words.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (predicted_words.size() == 0)
                begin
                    $error("sample_out word with no prediction waiting: got %0d",
                           sample_out);
                    mismatches++;
                end
                else
                begin
                    oldest_word = predicted_words.pop_front();
                    if (sample_out !== oldest_word)
                    begin
                        $error("sample_out mismatch: expected %0d, got %0d",
                               oldest_word, sample_out);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
                predicted_words.push_back(filter_word(sample_in, cutoff, resonance));
        end
        pending_words = predicted_words.size();
    end

endmodule

FILE: tb/nonlinear_ladder_lowpass_top_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// nonlinear_ladder_lowpass_top_tb
// Drives the ladder low-pass with directed edge words and then random audio
// and full-range words under several idle and stall mixes, including a long
// output hold-off; the checker beside the block predicts and compares.
// ============================================================================
module nonlinear_ladder_lowpass_top_tb;
    import nll_pkg::*;

    localparam int PHASE_WORDS   = 445;
    localparam int PRESSURE_WORDS = 8;
    localparam int HOLD_CYCLES   = 600;
    localparam int STALL_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 160;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic signed [COEF_W-1:0]   cutoff;
    logic signed [COEF_W-1:0]   resonance;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [SAMPLE_W-1:0] sample_out;

    int mismatches;
    int pending_words;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_request;
    int quiet_cycles;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    nonlinear_ladder_lowpass_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .cutoff     (cutoff),
        .resonance  (resonance),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out)
    );

    nll_ladder_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample_in     (sample_in),
        .cutoff        (cutoff),
        .resonance     (resonance),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .sample_out    (sample_out),
        .mismatches    (mismatches),
        .pending_words (pending_words)
    );

    // Output side: random stalls, or a long hold-off when one is requested.
    initial
    begin
        int hold_len;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_len     = hold_request;
                hold_request = 0;
                out_ready <= 1'b0;
                repeat (hold_len) @(posedge clk);
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: ends the run when no word moves on either channel for too long.
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Offer one word and hold it until the block takes it.
    task automatic send_word(input logic signed [SAMPLE_W-1:0] s,
                             input logic signed [COEF_W-1:0]   c,
                             input logic signed [COEF_W-1:0]   r);
        in_valid  <= 1'b1;
        sample_in <= s;
        cutoff    <= c;
        resonance <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Mostly well-behaved audio settings, some with out-of-range cutoff or
    // strong resonance, the rest fully random bit patterns.
    task automatic send_random_word();
        logic [31:0]                raw_s;
        logic [31:0]                raw_c;
        logic [31:0]                raw_r;
        logic signed [SAMPLE_W-1:0] s;
        logic signed [COEF_W-1:0]   c;
        logic signed [COEF_W-1:0]   r;
        int                         mode;
        raw_s = $urandom();
        raw_c = $urandom();
        raw_r = $urandom();
        mode  = $urandom_range(99);
        if (mode < 55)
        begin
            s = SAMPLE_W'($urandom_range(6291454) - 3145727);
            c = COEF_W'($urandom_range(65536));
            r = COEF_W'($urandom_range(78643));
        end
        else if (mode < 70)
        begin
            s = SAMPLE_W'($urandom_range(8388606) - 4194303);
            c = raw_c[COEF_W-1:0];
            r = COEF_W'($urandom_range(131071));
        end
        else
        begin
            s = raw_s[SAMPLE_W-1:0];
            c = raw_c[COEF_W-1:0];
            r = raw_r[COEF_W-1:0];
        end
        send_word(s, c, r);
    endtask

    // Idle between words; the payload carries junk while valid is low.
    task automatic sender_gap();
        int gap;
        gap = 0;
        if (send_idle_pct > 0)
        begin
            while ($urandom_range(99) < send_idle_pct)
                gap++;
            if ($urandom_range(99) < 3)
                gap += $urandom_range(1, 160);
        end
        if (gap > 0)
        begin
            in_valid  <= 1'b0;
            sample_in <= SAMPLE_W'($urandom());
            cutoff    <= COEF_W'($urandom());
            resonance <= COEF_W'($urandom());
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering words until every predicted word has come out.
    task automatic drain_outputs();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending_words == 0);
    endtask

    // Stimulus and verdict.
    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        sample_in      = '0;
        cutoff         = '0;
        resonance      = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, tanh knee at +/-3.0, cutoff clamping on
        // both sides, and full resonance of both signs on the ladder.
        send_word(24'sd0, 18'sd0, 18'sd0);
        send_word(24'sd8388607, 18'sd65536, 18'sd0);
        send_word(-24'sd8388608, 18'sd65536, 18'sd0);
        send_word(24'sd3145728, 18'sd65536, 18'sd0);
        send_word(24'sd3145727, 18'sd65536, 18'sd0);
        send_word(-24'sd3145728, 18'sd65536, 18'sd0);
        send_word(-24'sd3145727, 18'sd131071, 18'sd0);
        send_word(24'sd1048576, -18'sd131072, 18'sd65536);
        send_word(-24'sd1048576, -18'sd1, 18'sd65536);
        send_word(24'sd2097152, 18'sd65537, 18'sd131071);
        send_word(24'sd8388607, 18'sd65536, 18'sd131071);
        send_word(-24'sd8388608, 18'sd65536, -18'sd131072);
        send_word(24'sd8388607, 18'sd1, -18'sd131072);
        send_word(24'sd0, 18'sd65536, 18'sd131071);
        send_word(24'sd0, 18'sd65536, 18'sd131071);
        send_word(24'sd0, 18'sd65536, 18'sd131071);
        send_word(24'sd0, 18'sd65536, 18'sd131071);
        send_word(24'sd0, 18'sd65536, -18'sd131072);
        send_word(-24'sd1, 18'sd32768, 18'sd45875);
        send_word(24'sd1, 18'sd0, -18'sd1);
        drain_outputs();

        // Long output hold-off while words keep coming, so the input backs up.
        hold_request = HOLD_CYCLES;
        repeat (PRESSURE_WORDS)
            send_random_word();
        drain_outputs();

        // Random words under four idle and stall mixes.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            repeat (PHASE_WORDS)
            begin
                send_random_word();
                sender_gap();
            end
            drain_outputs();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_words == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
src/nll_pkg.sv
src/nll_mul.sv
src/nll_div.sv
src/nonlinear_ladder_lowpass_top.sv
tb/nll_ladder_checker.sv
tb/nonlinear_ladder_lowpass_top_tb.sv
